@@ hw/rtl/asc_pkg.sv @@
// Package for the aliquot sum classifier.
// Holds the controller states, the command and status words shared by
// the controller and datapath, and the fixed result width. No dependencies.
package asc_pkg;

  localparam int unsigned SumOutW = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ACCUM,
    ST_FINISH
  } asc_state_e;

  typedef struct packed {
    logic load;       // capture n, reset trial divisor and sum
    logic div_start;  // load remainder unit with n
    logic div_step;   // one restoring divide step
    logic accum;      // add divisor on zero remainder, advance divisor
    logic publish;    // move sum and flags to output register
  } asc_cmd_t;

  typedef struct packed {
    logic trial_done;  // divisor has reached n
    logic div_last;    // current step is the last bit of the remainder
    logic out_full;    // output register holds a word not taken this cycle
  } asc_status_t;

endpackage

@@ hw/rtl/asc_if.sv @@
// Valid/ready channel interfaces for the aliquot sum classifier.
// Depends on asc_pkg for the result width.
interface asc_in_if #(
  parameter int unsigned NUMBER_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface asc_out_if;
  import asc_pkg::*;
  logic               valid;
  logic               ready;
  logic [SumOutW-1:0] aliquot_sum;
  logic               is_perfect;
  logic               is_prime;

  modport source (output valid, output aliquot_sum, output is_perfect, output is_prime,
                  input ready);
  modport sink (input valid, input aliquot_sum, input is_perfect, input is_prime,
                output ready);
endinterface

@@ hw/rtl/asc_ctrl.sv @@
// Sequencer for the aliquot sum classifier.
// Steps the trial divisor loop and the bit-serial remainder unit through
// command words; depends on asc_pkg.
module asc_ctrl
  import asc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  asc_status_t status_i,
  output asc_cmd_t    cmd_o
);

  asc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.trial_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_FINISH: begin
        // hold until the output register frees up
        if (!status_i.out_full) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/asc_dpath.sv @@
// Datapath for the aliquot sum classifier: operand and trial divisor
// registers, a restoring remainder unit one bit per cycle, the running sum
// and the output register. Depends on asc_pkg.
module asc_dpath
  import asc_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  asc_cmd_t                cmd_i,
  output asc_status_t             status_o,
  input  logic [NUMBER_WIDTH-1:0] number_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SumOutW-1:0]      aliquot_sum_o,
  output logic                    is_perfect_o,
  output logic                    is_prime_o
);

  // aliquot sum stays below 8n for any n under 2^32
  localparam int unsigned SumW = NUMBER_WIDTH + 3;
  localparam int unsigned ExtW = (SumW > SumOutW) ? SumW : SumOutW;
  localparam int unsigned CntW = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

  logic [NUMBER_WIDTH-1:0] n_q;
  logic [NUMBER_WIDTH-1:0] div_q;
  logic [NUMBER_WIDTH-1:0] dvd_q, dvd_d;
  logic [NUMBER_WIDTH-1:0] rem_q, rem_d;
  logic [CntW-1:0]         cnt_q;
  logic [SumW-1:0]         sum_q;
  logic                    out_valid_q;
  logic [SumOutW-1:0]      out_sum_q;
  logic                    out_perfect_q;
  logic                    out_prime_q;

  logic [NUMBER_WIDTH:0]   rem_sh;
  logic [NUMBER_WIDTH-1:0] rem_sub;
  logic                    rem_ge;
  logic [ExtW-1:0]         sum_ext;
  logic                    perfect;
  logic                    prime;

  // restoring divide step: shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, dvd_q[NUMBER_WIDTH-1]};
  assign rem_sub = rem_sh[NUMBER_WIDTH-1:0] - div_q;
  assign rem_ge  = (rem_sh >= {1'b0, div_q});

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (cmd_i.div_start) begin
      rem_d = '0;
      dvd_d = n_q;
    end else if (cmd_i.div_step) begin
      rem_d = rem_ge ? rem_sub : rem_sh[NUMBER_WIDTH-1:0];
      dvd_d = {dvd_q[NUMBER_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (cmd_i.load) begin
      n_q   <= number_i;
      div_q <= NUMBER_WIDTH'(1);
      sum_q <= '0;
    end else if (cmd_i.accum) begin
      if (rem_q == '0) begin
        sum_q <= sum_q + SumW'(div_q);
      end
      div_q <= div_q + NUMBER_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  assign sum_ext = ExtW'(sum_q);
  assign perfect = (n_q != '0) && (sum_q == SumW'(n_q));
  assign prime   = (sum_q == SumW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_sum_q     <= sum_ext[SumOutW-1:0];
      out_perfect_q <= perfect;
      out_prime_q   <= prime;
    end
  end

  assign status_o.trial_done = (div_q >= n_q);
  assign status_o.div_last   = (cnt_q == CntW'(NUMBER_WIDTH - 1));
  assign status_o.out_full   = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign aliquot_sum_o = out_sum_q;
  assign is_perfect_o  = out_perfect_q;
  assign is_prime_o    = out_prime_q;

endmodule

@@ hw/rtl/aliquot_sum_classifier.sv @@
// Aliquot sum classifier: takes one unsigned word n and returns the sum of
// its divisors below n, a perfect flag (n > 0 and sum equal to n) and a prime
// flag (sum equal to one). Divisors are found by trial division of n by every
// i from 1 to n-1 in one shared remainder unit that resolves one bit per
// cycle, so the work for a word grows with n. One word is worked at a time;
// a finished result waits in an output register while the next word is
// accepted. Inputs 0 and 1 finish without any trial, with a sum of zero.
// Depends on asc_pkg, asc_if, asc_ctrl and asc_dpath.
module aliquot_sum_classifier
  import asc_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  asc_in_if.sink    in_i,
  asc_out_if.source out_o
);

  asc_cmd_t    cmd;
  asc_status_t status;

  asc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  asc_dpath #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .number_i      (in_i.number),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .aliquot_sum_o (out_o.aliquot_sum),
    .is_perfect_o  (out_o.is_perfect),
    .is_prime_o    (out_o.is_prime)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for aliquot_sum_classifier: feeds numbers over the
// input channel and checks each sum and flag pair against a local predictor.
// Depends on asc_pkg, asc_if and the classifier RTL.
module testbench;
  import asc_pkg::*;

  localparam int unsigned NumW      = 16;
  localparam int unsigned IdleLimit = 5_000_000;
  localparam int unsigned HoldLen   = 3000;
  localparam int unsigned SettleCyc = 64;

  typedef struct packed {
    logic [SumOutW-1:0] aliquot_sum;
    logic               is_perfect;
    logic               is_prime;
  } classify_t;

  logic clk_i;
  logic rst_ni;

  asc_in_if #(.NUMBER_WIDTH(NumW)) num_bus ();
  asc_out_if                       cls_bus ();

  aliquot_sum_classifier #(
    .NUMBER_WIDTH(NumW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (num_bus),
    .out_o (cls_bus)
  );

  classify_t   expected_results[$];
  int unsigned fail_count;
  bit          sender_idle;
  bit          recv_idle;
  int unsigned hold_len;
  int unsigned hold_seq;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned ready_gap;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Sum the divisors of n below n by pairing each d <= sqrt(n) with n / d.
  function automatic classify_t classify_number(input logic [NumW-1:0] n);
    longint unsigned nv;
    longint unsigned total;
    longint unsigned d;
    longint unsigned partner;
    classify_t       r;
    nv    = n;
    total = 0;
    if (nv != 0) begin
      for (d = 1; d * d <= nv; d++) begin
        if (nv % d == 0) begin
          partner = nv / d;
          total += d;
          if (partner != d) total += partner;
        end
      end
      total -= nv;
    end
    r.aliquot_sum = total[SumOutW-1:0];
    r.is_perfect  = (nv != 0) && (total == nv);
    r.is_prime    = (total == 1);
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random gaps on ready, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cls_bus.ready <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        cls_bus.ready <= 1'b0;
        hold_left--;
      end else if (ready_gap > 0) begin
        cls_bus.ready <= 1'b0;
        ready_gap--;
      end else begin
        cls_bus.ready <= 1'b1;
        ready_gap = recv_idle ? pick_gap() : 0;
      end
    end
  end

  // Compare each taken result word with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    classify_t want;
    if (rst_ni && cls_bus.valid && cls_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no number pending: aliquot_sum %0d", cls_bus.aliquot_sum);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (cls_bus.aliquot_sum !== want.aliquot_sum) begin
          $error("aliquot_sum: expected %0d, got %0d", want.aliquot_sum, cls_bus.aliquot_sum);
          fail_count++;
        end
        if (cls_bus.is_perfect !== want.is_perfect) begin
          $error("is_perfect: expected %0b, got %0b", want.is_perfect, cls_bus.is_perfect);
          fail_count++;
        end
        if (cls_bus.is_prime !== want.is_prime) begin
          $error("is_prime: expected %0b, got %0b", want.is_prime, cls_bus.is_prime);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long.
  always @(posedge clk_i) begin
    if ((num_bus.valid && num_bus.ready) || (cls_bus.valid && cls_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic offer_number(input logic [NumW-1:0] n);
    int unsigned gap;
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      num_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    num_bus.valid  <= 1'b1;
    num_bus.number <= n;
    do @(posedge clk_i); while (!num_bus.ready);
    expected_results.push_back(classify_number(n));
  endtask

  task automatic wait_for_results();
    num_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_reset();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Zero, one, small primes, squares, perfect and abundant numbers, all ones.
  task automatic run_directed();
    logic [NumW-1:0] picks[$];
    picks = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd12, 16'd25, 16'd28,
              16'd251, 16'd496, 16'd945, 16'd1024, 16'd8128, 16'd65535, 16'd0};
    sender_idle <= 1'b1;
    recv_idle   <= 1'b1;
    foreach (picks[k]) offer_number(picks[k]);
    wait_for_results();
  endtask

  task automatic run_streaming();
    sender_idle <= 1'b0;
    recv_idle   <= 1'b0;
    repeat (12) offer_number(NumW'($urandom_range(0, 40)));
    wait_for_results();
  endtask

  // Stall the output long enough that the block backs up into its input.
  task automatic run_backpressure();
    sender_idle <= 1'b0;
    recv_idle   <= 1'b0;
    hold_len    <= HoldLen;
    hold_seq    <= hold_seq + 1;
    repeat (8) offer_number(NumW'($urandom_range(2, 30)));
    wait_for_results();
  endtask

  // Hold the sender until every result is back, then resume.
  task automatic run_drain_pause();
    sender_idle <= 1'b1;
    recv_idle   <= 1'b1;
    repeat (4) offer_number(NumW'($urandom_range(0, 100)));
    wait_for_results();
    repeat (4) offer_number(NumW'($urandom_range(0, 100)));
    wait_for_results();
  endtask

  // Keep most numbers small; trial division cost grows with n.
  task automatic run_random();
    int unsigned r;
    logic [NumW-1:0] n;
    sender_idle <= 1'b1;
    recv_idle   <= 1'b1;
    repeat (56) begin
      r = $urandom_range(0, 99);
      if (r < 90) n = NumW'($urandom_range(0, 255));
      else if (r < 99) n = NumW'($urandom_range(256, 1023));
      else n = NumW'($urandom_range(1024, 4095));
      offer_number(n);
    end
    wait_for_results();
  endtask

  initial begin
    rst_ni         = 1'b0;
    num_bus.valid  = 1'b0;
    num_bus.number = '0;
    cls_bus.ready  = 1'b0;
    fail_count     = 0;
    sender_idle    = 1'b0;
    recv_idle      = 1'b0;
    hold_len       = 0;
    hold_seq       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    ready_gap      = 0;
    quiet_cycles   = 0;

    run_reset();
    run_directed();
    run_streaming();
    run_backpressure();
    run_drain_pause();
    run_random();

    num_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
